// ----- hw/rtl/tpm_pkg.sv -----
// Shared types, constants and helpers for the tree parity machine.
// Used by the channel interfaces, the lanes, the merge stage and the top level.
// No dependencies.
package tpm_pkg;

    // Default sizes of the machine
    localparam int UNITS_MAX_DEF  = 4;
    localparam int INPUTS_MAX_DEF = 16;
    localparam int DEPTH_MAX_DEF  = 15;

    // Fixed field widths
    localparam int WEIGHT_W   = 5;
    localparam int INDEX_W    = 6;
    localparam int BITS_W     = 64;
    localparam int SIGNS_W    = 4;
    localparam int UNITS_W    = 3;
    localparam int INPUTS_W   = 5;
    localparam int DEPTH_W    = 4;
    localparam int RULE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_UNIT_COUNT      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INPUTS_PER_UNIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_DEPTH    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RULE   = 2'd3;

    // Learning rule codes
    localparam logic [RULE_W-1:0] RULE_HEBBIAN = 2'd0;
    localparam logic [RULE_W-1:0] RULE_ANTI    = 2'd1;
    localparam logic [RULE_W-1:0] RULE_WALK    = 2'd2;
    localparam logic [RULE_W-1:0] RULE_NONE    = 2'd3;

    // Operation codes of an input item
    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_READ    = 2'd1,
        OP_PRESENT = 2'd2,
        OP_UPDATE  = 2'd3
    } t_op;

    // Control from the top level to every lane
    typedef struct packed {
        logic                       do_exec;  // write, update, read, group sums
        logic                       do_sum;   // final lane sum
        t_op                        op;
        logic [INDEX_W-1:0]         index;
        logic signed [WEIGHT_W-1:0] wvalue;
        logic [INPUTS_W-1:0]        eff_n;    // inputs in use, 1..INPUTS_MAX
        logic [DEPTH_W-1:0]         depth;    // effective depth
        logic                       upd_neg;  // learning factor is -1
    } t_lane_ctl;

    // Clamp a widened weight to -d..+d
    function automatic logic signed [WEIGHT_W-1:0] clamp_w(
        input logic signed [WEIGHT_W:0] v,
        input logic [DEPTH_W-1:0]       d
    );
        logic signed [WEIGHT_W:0] hi;
        logic signed [WEIGHT_W:0] lo;
        hi = $signed({{(WEIGHT_W + 1 - DEPTH_W){1'b0}}, d});
        lo = -hi;
        if (v > hi) begin
            return hi[WEIGHT_W-1:0];
        end else if (v < lo) begin
            return lo[WEIGHT_W-1:0];
        end
        return v[WEIGHT_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/tpm_in_if.sv -----
// Input channel of the tree parity machine: valid/ready plus one item.
// Depends on tpm_pkg.
interface tpm_in_if import tpm_pkg::*; ();
    logic                       valid;
    logic                       ready;
    t_op                        operation;
    logic [INDEX_W-1:0]         weight_index;
    logic signed [WEIGHT_W-1:0] weight_value;
    logic [BITS_W-1:0]          input_bits;

    modport source (output valid, operation, weight_index, weight_value, input_bits,
                    input ready);
    modport sink   (input valid, operation, weight_index, weight_value, input_bits,
                    output ready);
endinterface

// ----- hw/rtl/tpm_out_if.sv -----
// Result channel of the tree parity machine: valid/ready plus one item.
// Depends on tpm_pkg.
interface tpm_out_if import tpm_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       output_tau;
    logic [SIGNS_W-1:0]         hidden_signs;
    logic signed [WEIGHT_W-1:0] read_value;

    modport source (output valid, output_tau, hidden_signs, read_value, input ready);
    modport sink   (input valid, output_tau, hidden_signs, read_value, output ready);
endinterface

// ----- hw/rtl/tpm_lane.sv -----
// One hidden unit: its weight registers, write/read/update logic and a
// two-stage registered adder tree for the dot product.
// Depends on tpm_pkg.
module tpm_lane import tpm_pkg::*; #(
    parameter int INPUTS_MAX = INPUTS_MAX_DEF,
    parameter int BASE       = 0,
    parameter int SUM_W      = WEIGHT_W + $clog2(INPUTS_MAX) + 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_lane_ctl               i_ctl,
    input  logic                    i_upd,   // this unit agrees with tau
    input  logic [INPUTS_MAX-1:0]   i_x,     // inputs of the item being presented
    input  logic [INPUTS_MAX-1:0]   i_lx,    // inputs kept from the last present
    output logic signed [SUM_W-1:0] o_sum,
    output logic                    o_hit,
    output logic signed [WEIGHT_W-1:0] o_read
);

    localparam int POS_W = (INPUTS_MAX > 1) ? $clog2(INPUTS_MAX) : 1;
    localparam int NGRP  = (INPUTS_MAX + 3) / 4;
    localparam logic signed [WEIGHT_W:0] STEP_UP = (WEIGHT_W + 1)'(1);
    localparam logic signed [WEIGHT_W:0] STEP_DN = -(WEIGHT_W + 1)'(1);

    logic signed [WEIGHT_W-1:0] r_w   [INPUTS_MAX];
    logic signed [WEIGHT_W-1:0] n_w   [INPUTS_MAX];
    logic signed [SUM_W-1:0]    r_grp [NGRP];
    logic signed [SUM_W-1:0]    n_grp [NGRP];
    logic signed [SUM_W-1:0]    r_sum;
    logic signed [SUM_W-1:0]    n_sum;
    logic signed [WEIGHT_W-1:0] r_read;
    logic [INDEX_W-1:0]         off;
    logic [POS_W-1:0]           pos;

    // Address decode: this lane owns BASE .. BASE+INPUTS_MAX-1
    assign off   = i_ctl.index - INDEX_W'(BASE);
    assign pos   = off[POS_W-1:0];
    assign o_hit = (i_ctl.index >= INDEX_W'(BASE)) && (off < INDEX_W'(INPUTS_MAX));

    // Next weights: clamped write, or learning step on the inputs in use
    always_comb begin
        n_w = r_w;
        if (i_ctl.do_exec && (i_ctl.op == OP_WRITE) && o_hit) begin
            n_w[pos] = clamp_w((WEIGHT_W + 1)'(i_ctl.wvalue), i_ctl.depth);
        end
        if (i_ctl.do_exec && (i_ctl.op == OP_UPDATE) && i_upd) begin
            for (int j = 0; j < INPUTS_MAX; j++) begin
                if (INPUTS_W'(j) < i_ctl.eff_n) begin
                    n_w[j] = clamp_w((WEIGHT_W + 1)'(r_w[j]) +
                                     ((i_lx[j] ^ i_ctl.upd_neg) ? STEP_UP : STEP_DN),
                                     i_ctl.depth);
                end
            end
        end
    end

    // First tree level: signed terms summed in groups of four
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_grp[g] = '0;
            for (int k = 0; k < 4; k++) begin
                if ((g * 4 + k) < INPUTS_MAX) begin
                    if (INPUTS_W'(g * 4 + k) < i_ctl.eff_n) begin
                        if (i_x[g * 4 + k]) begin
                            n_grp[g] = n_grp[g] + SUM_W'(r_w[g * 4 + k]);
                        end else begin
                            n_grp[g] = n_grp[g] - SUM_W'(r_w[g * 4 + k]);
                        end
                    end
                end
            end
        end
    end

    // Second tree level
    always_comb begin
        n_sum = '0;
        for (int g = 0; g < NGRP; g++) begin
            n_sum = n_sum + r_grp[g];
        end
    end

    // Weight registers, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < INPUTS_MAX; j++) begin
                r_w[j] <= '0;
            end
        end else begin
            r_w <= n_w;
        end
    end

    // Tree and read data registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.do_exec) begin
            r_grp  <= n_grp;
            r_read <= r_w[pos];
        end
        if (i_ctl.do_sum) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum  = r_sum;
    assign o_read = r_read;

endmodule

// ----- hw/rtl/tpm_merge.sv -----
// Merge stage: hidden signs and tau from the lane sums, and the read value
// from the lane that owns the addressed weight.
// Depends on tpm_pkg.
module tpm_merge import tpm_pkg::*; #(
    parameter int UNITS_MAX = UNITS_MAX_DEF,
    parameter int SUM_W     = 10
) (
    input  logic signed [SUM_W-1:0]    i_sum  [UNITS_MAX],
    input  logic [UNITS_MAX-1:0]       i_hit,
    input  logic signed [WEIGHT_W-1:0] i_read [UNITS_MAX],
    input  logic [UNITS_W-1:0]         i_eff_k,
    output logic [SIGNS_W-1:0]         o_signs,
    output logic                       o_tau,
    output logic signed [WEIGHT_W-1:0] o_read
);

    logic neg_par;

    // Signs of the units in use; a zero sum counts as negative
    always_comb begin
        o_signs = '0;
        neg_par = 1'b0;
        for (int u = 0; u < UNITS_MAX; u++) begin
            if (UNITS_W'(u) < i_eff_k) begin
                if (i_sum[u] > 0) begin
                    o_signs[u] = 1'b1;
                end else begin
                    neg_par = ~neg_par;
                end
            end
        end
        o_tau = ~neg_par;
    end

    // At most one lane owns an index; none means the index is off the store
    always_comb begin
        o_read = '0;
        for (int u = 0; u < UNITS_MAX; u++) begin
            if (i_hit[u]) begin
                o_read = o_read | i_read[u];
            end
        end
    end

endmodule

// ----- hw/rtl/tree_parity_machine_top.sv -----
// Tree parity machine top level: one lane per hidden unit plus merge stage.
// An accepted item passes the exec, sum and merge steps before its result is
// registered; a new item is accepted only in the idle state, after the merge
// step of the last one. A stalled result holds the merge step. Reset (sync, active
// low) clears all weights, last state and output; registers reset to 3 units,
// 16 inputs, depth 3, Hebbian rule.
// Depends on tpm_pkg, tpm_in_if, tpm_out_if, tpm_lane, tpm_merge.
module tree_parity_machine_top import tpm_pkg::*; #(
    parameter int UNITS_MAX  = UNITS_MAX_DEF,
    parameter int INPUTS_MAX = INPUTS_MAX_DEF,
    parameter int DEPTH_MAX  = DEPTH_MAX_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    tpm_in_if.sink                i_item,
    tpm_out_if.source             o_result
);

    localparam int SUM_W = WEIGHT_W + $clog2(INPUTS_MAX) + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SUM,
        S_MERGE
    } t_state;

    t_state r_state;

    // Configuration
    logic [UNITS_W-1:0]  r_units;
    logic [INPUTS_W-1:0] r_inputs;
    logic [DEPTH_W-1:0]  r_depth;
    logic [RULE_W-1:0]   r_rule;
    logic [UNITS_W-1:0]  eff_k;
    logic [INPUTS_W-1:0] eff_n;
    logic [DEPTH_W-1:0]  eff_d;

    // Latched item and state kept from the last present
    t_op                        r_op;
    logic [INDEX_W-1:0]         r_index;
    logic signed [WEIGHT_W-1:0] r_value;
    logic [BITS_W-1:0]          r_bits;
    logic [BITS_W-1:0]          r_last_bits;
    logic [SIGNS_W-1:0]         r_last_signs;
    logic                       r_last_tau;

    // Output register
    logic                       r_out_valid;
    logic                       r_out_tau;
    logic [SIGNS_W-1:0]         r_out_signs;
    logic signed [WEIGHT_W-1:0] r_out_read;

    // Lane and merge wiring
    t_lane_ctl                  lane_ctl;
    logic [UNITS_MAX-1:0]       lane_upd;
    logic [UNITS_MAX-1:0]       lane_hit;
    logic signed [SUM_W-1:0]    lane_sum  [UNITS_MAX];
    logic signed [WEIGHT_W-1:0] lane_read [UNITS_MAX];
    logic [SIGNS_W-1:0]         m_signs;
    logic                       m_tau;
    logic signed [WEIGHT_W-1:0] m_read;
    logic                       in_acc;
    logic                       out_take;
    logic                       out_free;

    // Effective register values
    always_comb begin
        if (r_units == '0) begin
            eff_k = UNITS_W'(1);
        end else if (r_units > UNITS_W'(UNITS_MAX)) begin
            eff_k = UNITS_W'(UNITS_MAX);
        end else begin
            eff_k = r_units;
        end
        if (r_inputs == '0) begin
            eff_n = INPUTS_W'(1);
        end else if (r_inputs > INPUTS_W'(INPUTS_MAX)) begin
            eff_n = INPUTS_W'(INPUTS_MAX);
        end else begin
            eff_n = r_inputs;
        end
        if (r_depth > DEPTH_W'(DEPTH_MAX)) begin
            eff_d = DEPTH_W'(DEPTH_MAX);
        end else begin
            eff_d = r_depth;
        end
    end

    assign in_acc       = i_item.valid && i_item.ready;
    assign out_take     = r_out_valid && o_result.ready;
    assign out_free     = !r_out_valid || o_result.ready;
    assign i_item.ready = (r_state == S_IDLE);

    // Lane control
    always_comb begin
        lane_ctl.do_exec = (r_state == S_EXEC);
        lane_ctl.do_sum  = (r_state == S_SUM);
        lane_ctl.op      = r_op;
        lane_ctl.index   = r_index;
        lane_ctl.wvalue  = r_value;
        lane_ctl.eff_n   = eff_n;
        lane_ctl.depth   = eff_d;
        unique case (r_rule)
            RULE_HEBBIAN: lane_ctl.upd_neg = ~r_last_tau;
            RULE_ANTI:    lane_ctl.upd_neg = r_last_tau;
            default:      lane_ctl.upd_neg = 1'b0;
        endcase
    end

    // One lane per hidden unit; learning only where the unit agrees with tau
    for (genvar u = 0; u < UNITS_MAX; u++) begin : g_lane
        assign lane_upd[u] = (r_rule != RULE_NONE) && (UNITS_W'(u) < eff_k) &&
                             (r_last_signs[u] == r_last_tau);

        tpm_lane #(
            .INPUTS_MAX (INPUTS_MAX),
            .BASE       (u * INPUTS_MAX),
            .SUM_W      (SUM_W)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (lane_ctl),
            .i_upd   (lane_upd[u]),
            .i_x     (r_bits[u * INPUTS_MAX +: INPUTS_MAX]),
            .i_lx    (r_last_bits[u * INPUTS_MAX +: INPUTS_MAX]),
            .o_sum   (lane_sum[u]),
            .o_hit   (lane_hit[u]),
            .o_read  (lane_read[u])
        );
    end

    tpm_merge #(
        .UNITS_MAX (UNITS_MAX),
        .SUM_W     (SUM_W)
    ) u_merge (
        .i_sum   (lane_sum),
        .i_hit   (lane_hit),
        .i_read  (lane_read),
        .i_eff_k (eff_k),
        .o_signs (m_signs),
        .o_tau   (m_tau),
        .o_read  (m_read)
    );

    // Sequencer, configuration, kept state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_units      <= UNITS_W'(3);
            r_inputs     <= INPUTS_W'(16);
            r_depth      <= DEPTH_W'(3);
            r_rule       <= RULE_HEBBIAN;
            r_index      <= '0;
            r_last_bits  <= '0;
            r_last_signs <= '0;
            r_last_tau   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_out_tau    <= 1'b0;
            r_out_signs  <= '0;
            r_out_read   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_UNIT_COUNT:      r_units  <= i_cfg_data[UNITS_W-1:0];
                    REG_INPUTS_PER_UNIT: r_inputs <= i_cfg_data[INPUTS_W-1:0];
                    REG_WEIGHT_DEPTH:    r_depth  <= i_cfg_data[DEPTH_W-1:0];
                    REG_LEARNING_RULE:   r_rule   <= i_cfg_data[RULE_W-1:0];
                endcase
            end

            // a result taken while the merge step refills the register stays valid
            if (out_take && !((r_state == S_MERGE) && out_free)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_op    <= i_item.operation;
                        r_index <= i_item.weight_index;
                        r_value <= i_item.weight_value;
                        r_bits  <= i_item.input_bits;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_state <= S_MERGE;
                end
                S_MERGE: begin
                    // hold here until the output register can take the item
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        if (r_op == OP_PRESENT) begin
                            r_last_bits  <= r_bits;
                            r_last_signs <= m_signs;
                            r_last_tau   <= m_tau;
                            r_out_signs  <= m_signs;
                            r_out_tau    <= m_tau;
                        end else begin
                            r_out_signs  <= r_last_signs;
                            r_out_tau    <= r_last_tau;
                        end
                        r_out_read <= (r_op == OP_READ) ? m_read : '0;
                        r_state    <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.output_tau   = r_out_tau;
    assign o_result.hidden_signs = r_out_signs;
    assign o_result.read_value   = r_out_read;

    // A new result appears only out of the merge step
    a_result_from_merge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_MERGE))
        else $error("result valid rose outside the merge step");

    // An accepted item always starts lane work in the next cycle
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_EXEC))
        else $error("accepted item did not enter the exec step");

    // Lane address ranges never overlap
    a_one_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(lane_hit))
        else $error("more than one lane claims the weight index");

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for tree_parity_machine_top: directed items, then random key-exchange
// rounds under several register settings and idle patterns. Needs tpm_pkg and the channel ifs.
module testbench;
    import tpm_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 10;
    localparam int HOLD_CYCLES   = 400;
    localparam int STORE_SIZE    = UNITS_MAX_DEF * INPUTS_MAX_DEF;

    // One result item: tau, hidden signs and read-back weight
    typedef struct packed {
        logic                       tau;
        logic [SIGNS_W-1:0]         signs;
        logic signed [WEIGHT_W-1:0] rd;
    } t_tpm_output;

    // Mirror of the machine state; predicts each result and matches the DUT's output
    class parity_machine_mirror;
        int                  weights [STORE_SIZE];
        logic [BITS_W-1:0]   seen_bits;
        logic [SIGNS_W-1:0]  seen_signs;
        logic                seen_tau;
        logic [UNITS_W-1:0]  units_reg;
        logic [INPUTS_W-1:0] inputs_reg;
        logic [DEPTH_W-1:0]  depth_reg;
        logic [RULE_W-1:0]   rule_reg;
        t_tpm_output         pending_outputs [$];
        int                  errors;

        function new();
            foreach (weights[p]) weights[p] = 0;
            seen_bits  = '0;
            seen_signs = '0;
            seen_tau   = 1'b0;
            units_reg  = 3'd3;
            inputs_reg = 5'd16;
            depth_reg  = 4'd3;
            rule_reg   = RULE_HEBBIAN;
            errors     = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_UNIT_COUNT:      units_reg  = data[UNITS_W-1:0];
                REG_INPUTS_PER_UNIT: inputs_reg = data[INPUTS_W-1:0];
                REG_WEIGHT_DEPTH:    depth_reg  = data[DEPTH_W-1:0];
                default:             rule_reg   = data[RULE_W-1:0];
            endcase
        endfunction

        // Out-of-range register values fold to the nearest legal setting
        function int units_used();
            if (units_reg == 0) return 1;
            if (int'(units_reg) > UNITS_MAX_DEF) return UNITS_MAX_DEF;
            return int'(units_reg);
        endfunction

        function int inputs_used();
            if (inputs_reg == 0) return 1;
            if (int'(inputs_reg) > INPUTS_MAX_DEF) return INPUTS_MAX_DEF;
            return int'(inputs_reg);
        endfunction

        function int clamp_weight(int v);
            int d;
            d = (int'(depth_reg) > DEPTH_MAX_DEF) ? DEPTH_MAX_DEF : int'(depth_reg);
            if (v > d) return d;
            if (v < -d) return -d;
            return v;
        endfunction

        function int bit_sign(int p);
            return seen_bits[p] ? 1 : -1;
        endfunction

        // Dot product per unit; zero sum counts as negative, tau from the parity of negatives
        function void present_bits(logic [BITS_W-1:0] bits);
            int i, j, p, sum, negatives;
            logic [SIGNS_W-1:0] signs;
            seen_bits = bits;
            signs     = '0;
            negatives = 0;
            for (i = 0; i < units_used(); i++) begin
                sum = 0;
                for (j = 0; j < inputs_used(); j++) begin
                    p = i * INPUTS_MAX_DEF + j;
                    sum += weights[p] * bit_sign(p);
                end
                if (sum > 0) signs[i] = 1'b1;
                else negatives++;
            end
            seen_signs = signs;
            seen_tau   = (negatives % 2 == 0);
        endfunction

        // Learning step on the units that agreed with tau at the last present
        function void learn();
            int i, j, p, tau_s, factor, h;
            tau_s = seen_tau ? 1 : -1;
            case (rule_reg)
                RULE_HEBBIAN: factor = tau_s;
                RULE_ANTI:    factor = -tau_s;
                RULE_WALK:    factor = 1;
                default:      return;
            endcase
            for (i = 0; i < units_used(); i++) begin
                h = seen_signs[i] ? 1 : -1;
                if (h == tau_s) begin
                    for (j = 0; j < inputs_used(); j++) begin
                        p = i * INPUTS_MAX_DEF + j;
                        weights[p] = clamp_weight(weights[p] + factor * bit_sign(p));
                    end
                end
            end
        endfunction

        function void accept_item(t_op op, logic [INDEX_W-1:0] idx,
                                  logic signed [WEIGHT_W-1:0] val, logic [BITS_W-1:0] bits);
            t_tpm_output exp_out;
            int rd;
            bit in_store;
            rd       = 0;
            in_store = (int'(idx) / INPUTS_MAX_DEF) < UNITS_MAX_DEF;
            case (op)
                OP_WRITE:   if (in_store) weights[idx] = clamp_weight(int'(val));
                OP_READ:    if (in_store) rd = weights[idx];
                OP_PRESENT: present_bits(bits);
                default:    learn();
            endcase
            exp_out.tau   = seen_tau;
            exp_out.signs = seen_signs;
            exp_out.rd    = rd[WEIGHT_W-1:0];
            pending_outputs.push_back(exp_out);
        endfunction

        function void match_output(logic tau, logic [SIGNS_W-1:0] signs,
                                   logic signed [WEIGHT_W-1:0] rd);
            t_tpm_output exp_out;
            if (pending_outputs.size() == 0) begin
                $display("%0t: result with nothing pending: tau %b signs %b read %0d",
                         $time, tau, signs, rd);
                errors++;
                return;
            end
            exp_out = pending_outputs.pop_front();
            if (tau !== exp_out.tau) begin
                $display("%0t: output_tau expected %b actual %b", $time, exp_out.tau, tau);
                errors++;
            end
            if (signs !== exp_out.signs) begin
                $display("%0t: hidden_signs expected %b actual %b", $time, exp_out.signs, signs);
                errors++;
            end
            if (rd !== exp_out.rd) begin
                $display("%0t: read_value expected %0d actual %0d", $time, exp_out.rd, rd);
                errors++;
            end
        endfunction

        function int pending();
            return pending_outputs.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    tpm_in_if  item_ch ();
    tpm_out_if result_ch ();

    parity_machine_mirror mirror;
    int send_idle_pct;
    int recv_stall_pct;
    int items_sent;
    int cycle_count;
    int hold_left;
    bit hold_go;
    bit hold_seen;

    tree_parity_machine_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (item_ch),
        .o_result    (result_ch)
    );

    always #2 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off on each toggle of hold_go
    always @(posedge i_clk) begin
        if (hold_go != hold_seen) begin
            hold_seen = hold_go;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            result_ch.ready <= 1'b0;
        end else begin
            result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Check each accepted result
    always @(posedge i_clk) begin
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            mirror.match_output(result_ch.output_tau, result_ch.hidden_signs,
                                result_ch.read_value);
        end
    end

    function automatic logic [BITS_W-1:0] random_bits();
        return {$urandom, $urandom};
    endfunction

    // Offer one item, with a random gap first; returns right after the accepting edge
    task automatic offer_item(input t_op op, input logic [INDEX_W-1:0] idx,
                              input logic [WEIGHT_W-1:0] val, input logic [BITS_W-1:0] bits);
        while ($urandom_range(99) < send_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.operation    <= op;
        item_ch.weight_index <= idx;
        item_ch.weight_value <= val;
        item_ch.input_bits   <= bits;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        mirror.accept_item(op, idx, $signed(val), bits);
        items_sent++;
    endtask

    // Stop offering and let every pending result come back
    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        while (mirror.pending() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_register(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        mirror.set_register(idx, data);
    endtask

    task automatic apply_settings(input int units, input int inputs, input int depth,
                                  input int rule);
        load_register(REG_UNIT_COUNT, CFG_DATA_W'(units));
        load_register(REG_INPUTS_PER_UNIT, CFG_DATA_W'(inputs));
        load_register(REG_WEIGHT_DEPTH, CFG_DATA_W'(depth));
        load_register(REG_LEARNING_RULE, CFG_DATA_W'(rule));
        i_cfg_we <= 1'b0;
    endtask

    // Mostly present/update rounds with weight reloads and read-backs; some noise items
    task automatic exchange_rounds(input int count);
        int target, r, u, j;
        target = items_sent + count;
        while (items_sent < target) begin
            r = $urandom_range(99);
            if (r < 12) begin
                repeat ($urandom_range(8, 1)) begin
                    u = $urandom_range(mirror.units_used() - 1);
                    j = $urandom_range(mirror.inputs_used() - 1);
                    offer_item(OP_WRITE, INDEX_W'(u * INPUTS_MAX_DEF + j),
                               WEIGHT_W'($urandom_range(31)), random_bits());
                end
            end else if (r < 85) begin
                offer_item(OP_PRESENT, INDEX_W'($urandom_range(63)),
                           WEIGHT_W'($urandom_range(31)), random_bits());
                if ($urandom_range(3) != 0) begin
                    offer_item(OP_UPDATE, INDEX_W'($urandom_range(63)),
                               WEIGHT_W'($urandom_range(31)), random_bits());
                end
                if ($urandom_range(3) == 0) begin
                    offer_item(OP_READ, INDEX_W'($urandom_range(63)),
                               WEIGHT_W'($urandom_range(31)), random_bits());
                end
            end else begin
                offer_item(t_op'(2'($urandom_range(3))), INDEX_W'($urandom_range(63)),
                           WEIGHT_W'($urandom_range(31)), random_bits());
            end
        end
    endtask

    task automatic run_phase(input int units, input int inputs, input int depth, input int rule,
                             input int send_pct, input int stall_pct, input bit pressure,
                             input int count);
        wait_idle();
        apply_settings(units, inputs, depth, rule);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        if (pressure) hold_go <= ~hold_go;
        exchange_rounds(count);
    endtask

    initial begin
        i_clk                  = 1'b0;
        i_rst_n                = 1'b0;
        i_cfg_we               = 1'b0;
        i_cfg_index            = REG_UNIT_COUNT;
        i_cfg_data             = '0;
        item_ch.valid          = 1'b0;
        item_ch.operation      = OP_WRITE;
        item_ch.weight_index   = '0;
        item_ch.weight_value   = '0;
        item_ch.input_bits     = '0;
        result_ch.ready        = 1'b0;
        send_idle_pct          = 0;
        recv_stall_pct         = 0;
        items_sent             = 0;
        cycle_count            = 0;
        hold_left              = 0;
        hold_go                = 1'b0;
        hold_seen              = 1'b0;
        mirror                 = new();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: update from the reset state, clamped writes, unused-unit weights,
        // extreme input patterns, and a write between present and update
        offer_item(OP_UPDATE, 6'd0, 5'd0, '0);
        offer_item(OP_READ, 6'd0, 5'd0, '0);
        offer_item(OP_READ, 6'd63, 5'd0, '0);
        offer_item(OP_WRITE, 6'd0, 5'b01111, '0);
        offer_item(OP_WRITE, 6'd63, 5'b10000, '1);
        offer_item(OP_WRITE, 6'd17, 5'b10001, '0);
        offer_item(OP_WRITE, 6'd15, 5'b00010, '0);
        offer_item(OP_READ, 6'd0, 5'b11111, '1);
        offer_item(OP_READ, 6'd63, 5'd0, '0);
        offer_item(OP_READ, 6'd17, 5'd0, '0);
        offer_item(OP_READ, 6'd15, 5'd0, '0);
        offer_item(OP_PRESENT, 6'd0, 5'd0, '1);
        offer_item(OP_PRESENT, 6'd63, 5'd0, '0);
        offer_item(OP_PRESENT, 6'd0, 5'd0, 64'hA5A5_5A5A_F0F0_0F0F);
        offer_item(OP_WRITE, 6'd1, 5'b11101, '0);
        offer_item(OP_UPDATE, 6'd0, 5'd0, '0);
        offer_item(OP_READ, 6'd1, 5'd0, '0);
        offer_item(OP_READ, 6'd0, 5'd0, '0);
        offer_item(OP_PRESENT, 6'd5, 5'd3, random_bits());
        offer_item(OP_UPDATE, 6'd0, 5'd0, '0);
        offer_item(OP_READ, 6'd2, 5'd0, '0);

        // Random rounds: settings sweep, including folded values, depth zero and rule three
        run_phase(4, 16, 15, 0,  0,  0, 1'b0, 105);
        run_phase(4, 16,  3, 1, 80,  0, 1'b0, 105);
        run_phase(1,  1,  1, 2,  0, 80, 1'b0, 105);
        run_phase(0,  0,  0, 0, 37, 37, 1'b0, 105);
        run_phase(7, 31, 15, 3,  0,  0, 1'b1, 105);
        run_phase(2,  8,  5, 2, 80,  0, 1'b0, 105);
        run_phase(5, 17,  4, 1,  0, 80, 1'b0, 105);
        run_phase(3, 16,  3, 0, 37, 37, 1'b0, 105);
        run_phase(4,  5, 15, 2,  0,  0, 1'b0, 105);
        run_phase(4, 16,  7, 0, 37, 37, 1'b0, 105);

        wait_idle();
        if (mirror.errors == 0 && mirror.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
